// File: src/q24alu_pkg.sv
// Shared types, codes and the saturation helper of the Q24.8 fixed-point ALU.
// It depends on nothing; the divider and the top level use it.
package q24alu_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned QUOT_BITS = WORD_BITS + FRAC_BITS;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_GT       = 4'd4,
    MODE_LT       = 4'd5,
    MODE_GE       = 4'd6,
    MODE_LE       = 4'd7,
    MODE_EQ       = 4'd8,
    MODE_NE       = 4'd9,
    MODE_MAX      = 4'd10,
    MODE_MIN      = 4'd11,
    MODE_INC      = 4'd12,
    MODE_DEC      = 4'd13,
    MODE_FROM_INT = 4'd14,
    MODE_TO_INT   = 4'd15
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Result fields that travel beside the divider.
  typedef struct packed {
    logic    is_div;
    logic    qneg;
    logic    dz;
    word_t   res;
    logic    flag;
    status_t st;
  } side_t;

  // Builds a signed word from sign and magnitude; the top bit is the clamp flag.
  function automatic logic [WORD_BITS:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [63:0] limit;
    logic        ovf;
    word_t       m;
    limit = neg ? (64'd1 << (WORD_BITS - 1)) : ((64'd1 << (WORD_BITS - 1)) - 64'd1);
    ovf   = mag > limit;
    m     = ovf ? limit[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
    return {ovf, (neg ? (~m + word_t'(1)) : m)};
  endfunction

endpackage

// File: src/q24alu_div.sv
// Pipelined restoring divider of the Q24.8 ALU, one quotient bit per stage.
// It depends on q24alu_pkg for the word and quotient widths.
module q24alu_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic [q24alu_pkg::QUOT_BITS-1:0]    dividend,
  input  logic [q24alu_pkg::WORD_BITS-1:0]    divisor,
  output logic [q24alu_pkg::QUOT_BITS-1:0]    quotient
);

  localparam int unsigned W  = q24alu_pkg::WORD_BITS;
  localparam int unsigned QW = q24alu_pkg::QUOT_BITS;

  logic [W-1:0]  rem [QW];
  logic [QW-1:0] dvd [QW];
  logic [QW-1:0] quo [QW];
  logic [W-1:0]  dsr [QW];

  genvar i;
  generate
    for (i = 0; i < QW; i++) begin : g_stage
      logic [W-1:0]  rem_in;
      logic [QW-1:0] dvd_in;
      logic [QW-1:0] quo_in;
      logic [W-1:0]  dsr_in;
      logic [W+1:0]  trial;
      logic          ge;

      if (i == 0) begin : g_first
        assign rem_in = '0;
        assign dvd_in = dividend;
        assign quo_in = '0;
        assign dsr_in = divisor;
      end else begin : g_next
        assign rem_in = rem[i-1];
        assign dvd_in = dvd[i-1];
        assign quo_in = quo[i-1];
        assign dsr_in = dsr[i-1];
      end

      // A clear borrow means the shifted remainder covers the divisor.
      assign trial = {1'b0, rem_in, dvd_in[QW-1]} - {2'b00, dsr_in};
      assign ge    = ~trial[W+1];

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= ge ? trial[W-1:0] : {rem_in[W-2:0], dvd_in[QW-1]};
          dvd[i] <= {dvd_in[QW-2:0], 1'b0};
          quo[i] <= {quo_in[QW-2:0], ge};
          dsr[i] <= dsr_in;
        end
      end
    end
  endgenerate

  assign quotient = quo[QW-1];

endmodule

// File: src/q24_8_fixed_point_alu.sv
// Signed Q24.8 fixed-point ALU with stream ports.
// The pipeline is an input register, an arithmetic stage with the multiplier,
// 40 stages of the divider (one quotient bit each) and the output register.
// Throughput is one transfer per cycle; a stall on the output freezes the whole
// pipeline. Reset (rst, synchronous) clears only the valid bits of the stages.
// Depends on q24alu_pkg and q24alu_div.
module q24_8_fixed_point_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // mode [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value [31:0]
  output logic [2:0]  m_tuser    // compare_flag [0], status [2:1]
);

  localparam int unsigned W  = q24alu_pkg::WORD_BITS;
  localparam int unsigned F  = q24alu_pkg::FRAC_BITS;
  localparam int unsigned QW = q24alu_pkg::QUOT_BITS;

  // One enable moves every stage; it is high whenever the output slot is free
  // or is being emptied in this cycle.
  logic ce;
  assign ce       = ~m_tvalid | m_tready;
  assign s_tready = ce;

  // Stage 1: registered operands and their magnitudes.
  logic                v1;
  q24alu_pkg::mode_t   mode1;
  q24alu_pkg::word_t   a1, b1, ma1, mb1;
  logic                na1, nb1;
  q24alu_pkg::word_t   in_a, in_b;

  assign in_a = s_tdata[31:0];
  assign in_b = s_tdata[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mode1 <= q24alu_pkg::mode_t'(s_tuser);
      a1    <= in_a;
      b1    <= in_b;
      na1   <= in_a[W-1];
      nb1   <= in_b[W-1];
      ma1   <= in_a[W-1] ? (~in_a + q24alu_pkg::word_t'(1)) : in_a;
      mb1   <= in_b[W-1] ? (~in_b + q24alu_pkg::word_t'(1)) : in_b;
    end
  end

  // Stage 2: everything except multiply and divide is settled here, and the
  // magnitude product is registered. Add, subtract, increment and decrement
  // share one adder.
  q24alu_pkg::word_t   y, sum;
  logic                sub, same, add_ovf;
  logic                lt_ab, lt_ba, eq_ab;
  logic [W:0]          sm_from, sm_to;
  q24alu_pkg::word_t   res_c;
  logic                flag_c, ovf_c;

  assign y     = (mode1 == q24alu_pkg::MODE_INC || mode1 == q24alu_pkg::MODE_DEC)
                 ? q24alu_pkg::word_t'(1) : b1;
  assign sub   = (mode1 == q24alu_pkg::MODE_SUB || mode1 == q24alu_pkg::MODE_DEC);
  assign sum   = sub ? (a1 - y) : (a1 + y);
  assign same  = sub ? (a1[W-1] != y[W-1]) : (a1[W-1] == y[W-1]);
  assign add_ovf = same && (sum[W-1] != a1[W-1]);
  assign lt_ab = $signed(a1) < $signed(b1);
  assign lt_ba = $signed(b1) < $signed(a1);
  assign eq_ab = a1 == b1;
  assign sm_from = q24alu_pkg::sat_mag(na1, {{(64-W-F){1'b0}}, ma1, {F{1'b0}}});
  assign sm_to   = q24alu_pkg::sat_mag(na1, {{(64-W+F){1'b0}}, ma1[W-1:F]});

  always_comb begin
    res_c  = '0;
    flag_c = 1'b0;
    ovf_c  = 1'b0;
    unique case (mode1)
      q24alu_pkg::MODE_ADD, q24alu_pkg::MODE_SUB,
      q24alu_pkg::MODE_INC, q24alu_pkg::MODE_DEC: begin
        ovf_c = add_ovf;
        res_c = add_ovf ? (a1[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : sum;
      end
      q24alu_pkg::MODE_MUL, q24alu_pkg::MODE_DIV: begin
        res_c = '0;
      end
      q24alu_pkg::MODE_GT: flag_c = lt_ba;
      q24alu_pkg::MODE_LT: flag_c = lt_ab;
      q24alu_pkg::MODE_GE: flag_c = ~lt_ab;
      q24alu_pkg::MODE_LE: flag_c = ~lt_ba;
      q24alu_pkg::MODE_EQ: flag_c = eq_ab;
      q24alu_pkg::MODE_NE: flag_c = ~eq_ab;
      q24alu_pkg::MODE_MAX: res_c = lt_ba ? a1 : b1;
      q24alu_pkg::MODE_MIN: res_c = lt_ab ? a1 : b1;
      q24alu_pkg::MODE_FROM_INT: begin
        ovf_c = sm_from[W];
        res_c = sm_from[W-1:0];
      end
      q24alu_pkg::MODE_TO_INT: begin
        ovf_c = sm_to[W];
        res_c = sm_to[W-1:0];
      end
      default: res_c = '0;
    endcase
  end

  logic                v2;
  q24alu_pkg::mode_t   mode2;
  q24alu_pkg::word_t   res2, ma2, mb2;
  logic                flag2, ovf2, qneg2;
  logic [63:0]         prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mode2 <= mode1;
      res2  <= res_c;
      flag2 <= flag_c;
      ovf2  <= ovf_c;
      qneg2 <= na1 ^ nb1;
      ma2   <= ma1;
      mb2   <= mb1;
      prod2 <= 64'(ma1) * 64'(mb1);
    end
  end

  // Divider stages. The other results, including the saturated product, ride
  // a delay line of the same length beside it.
  logic [QW-1:0] quotient;

  q24alu_div u_div (
    .clk      (clk),
    .en       (ce),
    .dividend ({ma2, {F{1'b0}}}),
    .divisor  (mb2),
    .quotient (quotient)
  );

  logic [W:0]         sm_mul;
  q24alu_pkg::side_t  side_c;

  assign sm_mul = q24alu_pkg::sat_mag(qneg2, prod2 >> F);

  always_comb begin
    side_c        = '0;
    side_c.is_div = (mode2 == q24alu_pkg::MODE_DIV);
    side_c.qneg   = qneg2;
    side_c.dz     = (mb2 == '0);
    side_c.flag   = flag2;
    if (mode2 == q24alu_pkg::MODE_MUL) begin
      side_c.res = sm_mul[W-1:0];
      side_c.st  = sm_mul[W] ? q24alu_pkg::ST_OVF : q24alu_pkg::ST_OK;
    end else begin
      side_c.res = res2;
      side_c.st  = ovf2 ? q24alu_pkg::ST_OVF : q24alu_pkg::ST_OK;
    end
  end

  q24alu_pkg::side_t side_d [QW];
  logic [QW-1:0]     vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (ce) begin
      vd <= {vd[QW-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_d[0] <= side_c;
      for (int k = 1; k < QW; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Output register: the quotient is signed and saturated here, and a zero
  // divisor gives zero with its own status.
  q24alu_pkg::side_t side_o;
  logic [W:0]        sm_div;
  q24alu_pkg::word_t res_o;
  q24alu_pkg::status_t st_o;

  assign side_o = side_d[QW-1];
  assign sm_div = q24alu_pkg::sat_mag(side_o.qneg, {{(64-QW){1'b0}}, quotient});

  always_comb begin
    res_o = side_o.res;
    st_o  = side_o.st;
    if (side_o.is_div) begin
      if (side_o.dz) begin
        res_o = '0;
        st_o  = q24alu_pkg::ST_DIV0;
      end else begin
        res_o = sm_div[W-1:0];
        st_o  = sm_div[W] ? q24alu_pkg::ST_OVF : q24alu_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= vd[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= res_o;
      m_tuser <= {st_o, side_o.flag};
    end
  end

endmodule
